// ===== design/fed_pkg.sv =====
// shared types and constants for the feedback echo delay line
`default_nettype none

package fed_pkg;

    localparam int STORE_DEPTH_DEF = 65536;
    localparam int SAMPLE_W        = 16;
    localparam int CFG_W           = 17;
    localparam int FRAC_W          = 15;
    localparam int ECHO_OFFSET     = 600;
    localparam int LOOP_RESET      = 250;
    localparam int GAIN_FEEDBACK   = 22938;
    localparam int GAIN_OUTPUT     = 26214;
    localparam int ROUND_HALF      = 16384;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_LOOP_LENGTH = REG_IDX_W'(0);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MIX
    } fed_state_t;

    // control from the sequencer to the index unit
    typedef struct packed {
        logic load;
        logic advance;
    } idx_ctrl_t;

    // status from the index unit
    typedef struct packed {
        logic busy;
        logic echo_valid;
    } idx_stat_t;

endpackage

`default_nettype wire

// ===== design/fed_ram.sv =====
// delay store memory, one write and one registered read port
`default_nettype none

module fed_ram
    import fed_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  wire logic                aclk,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire logic [SAMPLE_W-1:0] wdata,
    input  wire logic                re,
    input  wire logic [AW-1:0]       raddr,
    output logic      [SAMPLE_W-1:0] rdata
);

    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/fed_mix.sv =====
// gain multiply stage and rounding / saturating sums
`default_nettype none

module fed_mix
    import fed_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       load,
    input  wire logic signed [SAMPLE_W-1:0] x,
    input  wire logic signed [SAMPLE_W-1:0] echo,
    output logic      signed [SAMPLE_W-1:0] fb_sum,
    output logic      signed [SAMPLE_W-1:0] out_sum
);

    localparam int PW = 2 * SAMPLE_W;
    localparam int AW = PW + 2;
    localparam int QW = AW - FRAC_W;

    localparam logic signed [SAMPLE_W-1:0] G_FB  = SAMPLE_W'(GAIN_FEEDBACK);
    localparam logic signed [SAMPLE_W-1:0] G_OUT = SAMPLE_W'(GAIN_OUTPUT);
    localparam logic signed [QW-1:0] Q_MAX = QW'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [QW-1:0] Q_MIN = -QW'(1 << (SAMPLE_W - 1));

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [PW-1:0]       p_fb_reg;
    logic signed [PW-1:0]       p_out_reg;

    function automatic logic signed [SAMPLE_W-1:0] mix_sat(
        input logic signed [SAMPLE_W-1:0] xs,
        input logic signed [PW-1:0]       p
    );
        logic signed [AW-1:0] acc;
        logic signed [QW-1:0] q;
        logic signed [SAMPLE_W-1:0] r;
        acc = (AW'(xs) <<< FRAC_W) + AW'(p) + AW'(ROUND_HALF);
        // floor of acc / 2^15
        q = acc[AW-1:FRAC_W];
        if (q > Q_MAX) begin
            r = Q_MAX[SAMPLE_W-1:0];
        end else if (q < Q_MIN) begin
            r = Q_MIN[SAMPLE_W-1:0];
        end else begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg     <= x;
            p_fb_reg  <= PW'(G_FB) * PW'(echo);
            p_out_reg <= PW'(G_OUT) * PW'(echo);
        end
    end

    assign fb_sum  = mix_sat(x_reg, p_fb_reg);
    assign out_sum = mix_sat(x_reg, p_out_reg);

endmodule

`default_nettype wire

// ===== design/fed_index.sv =====
// loop length, write position, echo index and fill tracking
`default_nettype none

module fed_index
    import fed_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int AW          = $clog2(STORE_DEPTH),
    parameter int LW          = $clog2(STORE_DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire idx_ctrl_t        ctrl,
    input  wire logic [CFG_W-1:0] cfg_value,
    output idx_stat_t             stat,
    output logic      [AW-1:0]    wr_pos,
    output logic      [AW-1:0]    rd_pos
);

    localparam int OW  = $clog2(ECHO_OFFSET + 1);
    localparam int BW  = $clog2(OW);
    localparam int NW  = $clog2(OW + 1);
    localparam int CW  = (LW > OW + 1) ? LW : OW + 1;
    localparam int VW  = (LW > CFG_W) ? LW : CFG_W;
    localparam logic [OW-1:0] OFF = OW'(ECHO_OFFSET);

    logic [LW-1:0] len_reg,  len_next;
    logic [AW-1:0] pos_reg,  pos_next;
    logic [AW-1:0] rd_reg,   rd_next;
    logic          wrap_reg, wrap_next;
    logic [OW-1:0] rem_reg,  rem_next;
    logic [NW-1:0] cnt_reg,  cnt_next;

    logic [LW-1:0] len_lim;
    logic [VW-1:0] v_ext;
    logic [BW-1:0] bit_idx;
    logic [OW:0]   t;
    logic          t_ge;
    logic [OW-1:0] rem_step;
    logic [LW-1:0] pos_inc;
    logic [LW-1:0] rd_inc;

    // clamp the written length to 1 .. STORE_DEPTH
    always_comb begin
        v_ext = VW'(cfg_value);
        if (cfg_value == '0) begin
            len_lim = LW'(1);
        end else if (v_ext > VW'(STORE_DEPTH)) begin
            len_lim = LW'(STORE_DEPTH);
        end else begin
            len_lim = v_ext[LW-1:0];
        end
    end

    // one restoring step of offset mod length
    always_comb begin
        bit_idx  = BW'(cnt_reg - NW'(1));
        t        = {rem_reg, OFF[bit_idx]};
        t_ge     = CW'(t) >= CW'(len_reg);
        rem_step = t_ge ? OW'(CW'(t) - CW'(len_reg)) : t[OW-1:0];
        pos_inc  = LW'(pos_reg) + LW'(1);
        rd_inc   = LW'(rd_reg) + LW'(1);
    end

    always_comb begin
        len_next  = len_reg;
        pos_next  = pos_reg;
        rd_next   = rd_reg;
        wrap_next = wrap_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (ctrl.load) begin
            len_next  = len_lim;
            pos_next  = '0;
            rd_next   = '0;
            wrap_next = 1'b0;
            rem_next  = '0;
            cnt_next  = NW'(OW);
        end else if (cnt_reg != '0) begin
            rem_next = rem_step;
            cnt_next = cnt_reg - NW'(1);
            if (cnt_reg == NW'(1)) begin
                rd_next = AW'(rem_step);
            end
        end else if (ctrl.advance) begin
            if (pos_inc == len_reg) begin
                pos_next  = '0;
                wrap_next = 1'b1;
            end else begin
                pos_next = pos_inc[AW-1:0];
            end
            if (rd_inc == len_reg) begin
                rd_next = '0;
            end else begin
                rd_next = rd_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= LW'(LOOP_RESET);
            pos_reg  <= '0;
            rd_reg   <= '0;
            wrap_reg <= 1'b0;
            rem_reg  <= '0;
            cnt_reg  <= NW'(OW);
        end else begin
            len_reg  <= len_next;
            pos_reg  <= pos_next;
            rd_reg   <= rd_next;
            wrap_reg <= wrap_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
        end
    end

    // entries below the position, or all after a wrap, hold written data
    assign stat.busy       = cnt_reg != '0;
    assign stat.echo_valid = wrap_reg || (rd_reg < pos_reg);
    assign wr_pos          = pos_reg;
    assign rd_pos          = rd_reg;

endmodule

`default_nettype wire

// ===== design/feedback_echo_delay.sv =====
// top level of the feedback echo delay line
`default_nettype none

// Feedback echo delay line. Each input transaction carries one signed Q1.15
// sample. The echo is read from the delay store at (position + 600) mod
// loop_length; the store receives sample + 0.7*echo at the position and the
// result transaction carries sample + 0.8*echo, both rounded and saturated
// to 16 bits. A sample goes through accept and memory read, gain multiply,
// sum and write back, in an order set by the read-modify-write through the
// single delay memory; the next sample is accepted once the previous one
// has been written back, even while its result still waits in the output
// register. After reset and after each loop_length write the block holds
// s_tready low while it works out the starting echo index. The store
// needs no clearing pass: entries not yet written since the last clear
// read as zero by tracking how far the write position has advanced.
module feedback_echo_delay
    import fed_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] sample_in
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [15:0]           m_tdata,   // [15:0] sample_out
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = $clog2(STORE_DEPTH + 1);

    fed_state_t state_reg, state_next;

    logic [CFG_W-1:0]    len_raw_reg;
    logic                cfg_wr;
    logic                in_xact;
    logic                done;

    logic                echo_ok_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] echo;
    logic signed [SAMPLE_W-1:0] fb_sum;
    logic signed [SAMPLE_W-1:0] out_sum;

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg;

    logic [SAMPLE_W-1:0] ram_rdata;
    logic [AW-1:0]       wr_pos;
    logic [AW-1:0]       rd_pos;
    idx_ctrl_t           idx_ctrl;
    idx_stat_t           idx_stat;
    logic                mix_load;

    // configuration writes, register index from the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_LOOP_LENGTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_raw_reg <= CFG_W'(LOOP_RESET);
        end else if (cfg_wr) begin
            len_raw_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_LOOP_LENGTH) begin
            prdata = APB_DATA_W'(len_raw_reg);
        end
    end

    // sequencer: accept, multiply, write back
    assign s_tready = (state_reg == ST_IDLE) && !idx_stat.busy;
    assign in_xact  = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        mix_load   = 1'b0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xact) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                mix_load   = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                // hold until the output register can take the result
                if (!out_valid_reg || m_tready) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sample and echo validity captured at accept time
    always_ff @(posedge aclk) begin
        if (in_xact) begin
            x_reg       <= s_tdata;
            echo_ok_reg <= idx_stat.echo_valid;
        end
    end

    // never-written entries read as zero
    assign echo = echo_ok_reg ? ram_rdata : '0;

    assign idx_ctrl.load    = cfg_wr;
    assign idx_ctrl.advance = done;

    fed_index #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW),
        .LW          (LW)
    ) u_index (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (idx_ctrl),
        .cfg_value (pwdata[CFG_W-1:0]),
        .stat      (idx_stat),
        .wr_pos    (wr_pos),
        .rd_pos    (rd_pos)
    );

    fed_ram #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (done),
        .waddr (wr_pos),
        .wdata (fb_sum),
        .re    (in_xact),
        .raddr (rd_pos),
        .rdata (ram_rdata)
    );

    fed_mix u_mix (
        .aclk    (aclk),
        .load    (mix_load),
        .x       (x_reg),
        .echo    (echo),
        .fb_sum  (fb_sum),
        .out_sum (out_sum)
    );

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (done) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            out_data_reg <= out_sum;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== verif/tb_feedback_echo_delay.sv =====
// testbench for the feedback echo delay line: directed and random samples against a predictor
`timescale 1ns / 1ps

module tb_feedback_echo_delay;
    import fed_pkg::*;

    localparam int  CLK_HALF    = 6;
    localparam int  RESET_LEN   = 6;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  TAIL_CYCLES = 10;
    localparam int  MAX_PRINTS  = 50;
    // register index that decodes to nothing
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_IDX_W'(1);

    // sample pattern kinds used by the random part
    typedef enum int {
        PAT_FULL,
        PAT_SMALL,
        PAT_HOLD,
        PAT_EXTREME
    } sample_pattern_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // [15:0] sample_in
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;   // [15:0] sample_out
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // echo predictor state
    logic signed [15:0] echo_line [STORE_DEPTH_DEF];
    int unsigned        echo_pos;
    int unsigned        echo_len;

    // expected sample_out values, oldest first
    logic [15:0] pending_out [$];

    int error_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;

    feedback_echo_delay dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #CLK_HALF;
        aclk = 1'b0;
        #CLK_HALF;
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_out.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (error_count < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s, got %0d expected %0d", cycle_count, what,
                     $signed(got), $signed(want));
        error_count++;
    endtask

    // result checker: every accepted result transaction against the oldest expectation
    always @(posedge aclk) begin
        logic [15:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                report_mismatch("result transaction with nothing pending", m_tdata, 16'h0);
            end else begin
                want = pending_out.pop_front();
                if (m_tdata !== want)
                    report_mismatch("sample_out", m_tdata, want);
            end
        end
    end

    // round half up at the q1.15 point, then clamp to 16 bits
    function automatic logic signed [15:0] mix_and_saturate(input logic signed [15:0] x,
                                                           input logic signed [15:0] echo,
                                                           input int gain);
        longint acc;
        acc = longint'(x) * 32768 + longint'(gain) * longint'(echo) + ROUND_HALF;
        acc = acc >>> FRAC_W;
        if (acc > 32767)
            acc = 32767;
        if (acc < -32768)
            acc = -32768;
        return 16'(acc);
    endfunction

    // advance the echo predictor by one accepted sample
    task automatic predict_echo_output(input logic signed [15:0] x);
        int unsigned        pos;
        int unsigned        rd;
        logic signed [15:0] echo;
        pos = echo_pos;
        if (pos >= echo_len)
            pos = 0;
        rd = (pos + ECHO_OFFSET) % echo_len;
        // read before write, so a tap on the write slot sees the old entry
        echo = echo_line[rd];
        echo_line[pos] = mix_and_saturate(x, echo, GAIN_FEEDBACK);
        pending_out.push_back(mix_and_saturate(x, echo, GAIN_OUTPUT));
        pos++;
        if (pos >= echo_len)
            pos = 0;
        echo_pos = pos;
    endtask

    // a loop_length write clamps the length and empties the line
    task automatic set_loop_length(input logic [CFG_W-1:0] value);
        if (value == 0)
            echo_len = 1;
        else if (value > STORE_DEPTH_DEF)
            echo_len = STORE_DEPTH_DEF;
        else
            echo_len = 32'(value);
        foreach (echo_line[i])
            echo_line[i] = '0;
        echo_pos = 0;
    endtask

    // one input transaction, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [15:0] x);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = x;
        do
            @(posedge aclk);
        while (!s_tready);
        predict_echo_output(x);
    endtask

    // stop sending until every expected result transaction has come back
    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_out.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // setup and access phase of one register write, called at a falling edge
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        if (idx == REG_LOOP_LENGTH)
            set_loop_length(value[CFG_W-1:0]);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // drain the line, then reconfigure it
    task automatic change_loop_length(input logic [APB_DATA_W-1:0] value);
        wait_for_drain();
        write_register(REG_LOOP_LENGTH, value);
    endtask

    // reset length: field extremes and alternating bit patterns
    task automatic test_reset_length();
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sh0001);
        send_sample(16'sh0001);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
    endtask

    // zero length acts as one, so the tap always lands on the write slot;
    // a held full-scale input drives the feedback into saturation
    task automatic test_single_entry_loop();
        change_loop_length(0);
        repeat (3) send_sample(16'sh7FFF);
        repeat (3) send_sample(-16'sh8000);
    endtask

    // lengths past the store depth clamp to it, an exact fit too
    task automatic test_length_clamp();
        change_loop_length(32'h1FFFF);
        send_sample(16'sh4000);
        send_sample(-16'sh4000);
        change_loop_length(STORE_DEPTH_DEF);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
    endtask

    // a write to an unmapped index must leave length and store alone
    task automatic test_unmapped_register();
        wait_for_drain();
        write_register(REG_UNMAPPED, 32'd5);
        send_sample(16'sh1234);
        send_sample(-16'sh1234);
        send_sample(16'sh7FFF);
    endtask

    // length equal to the tap offset: the tap again hits the write slot
    task automatic test_tap_on_write_slot();
        change_loop_length(ECHO_OFFSET);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        send_sample(16'sh0000);
    endtask

    function automatic logic [APB_DATA_W-1:0] pick_loop_length();
        case ($urandom_range(9))
            0:       return 1;
            1:       return 2;
            2:       return ECHO_OFFSET;
            3:       return ECHO_OFFSET + 1;
            4:       return ECHO_OFFSET / 2;
            5:       return $urandom_range(131071);
            6:       return $urandom_range(602, 1400);
            default: return $urandom_range(3, 599);
        endcase
    endfunction

    // random runs of samples over several loop lengths, with drain pauses
    task automatic run_random_phase(input int n_items, input int sender_pct,
                                    input int receiver_pct);
        sample_pattern_t    pattern;
        int                 run_left;
        int                 chunk_left;
        logic signed [15:0] held;
        logic signed [15:0] x;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        run_left   = 0;
        chunk_left = 0;
        for (int n = 0; n < n_items; n++) begin
            if (chunk_left == 0) begin
                change_loop_length(pick_loop_length());
                chunk_left = $urandom_range(80, 260);
            end
            if (run_left == 0) begin
                pattern  = sample_pattern_t'($urandom_range(3));
                run_left = $urandom_range(1, 40);
                held     = 16'($urandom());
            end
            case (pattern)
                PAT_SMALL:   x = 16'($signed($urandom_range(0, 2047)) - 1024);
                PAT_HOLD:    x = held;
                PAT_EXTREME: x = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
                default:     x = 16'($urandom());
            endcase
            send_sample(x);
            run_left--;
            chunk_left--;
            // now and then the sender holds off until the pipe is empty
            if ($urandom_range(149) == 0)
                wait_for_drain();
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(650, 26, 56);
        run_random_phase(650, 56, 26);
        run_random_phase(650, 0, 0);
    endtask

    initial begin
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        aresetn       = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 26;
        recv_idle_pct = 56;
        set_loop_length(CFG_W'(LOOP_RESET));
        repeat (RESET_LEN) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_length();
        test_single_entry_loop();
        test_length_clamp();
        test_unmapped_register();
        test_tap_on_write_slot();
        test_random_traffic();

        wait_for_drain();
        // let any late or stray result transaction show up
        repeat (TAIL_CYCLES) @(posedge aclk);
        while (pending_out.size() != 0)
            report_mismatch("result never arrived", 16'h0, pending_out.pop_front());
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
